// File: hw/rtl/named_region_registry_defines.svh
// Assertion macros shared by the named region registry RTL.
// Each macro expects clk and rst in scope of the module that uses it.
`ifndef NAMED_REGION_REGISTRY_DEFINES_SVH
`define NAMED_REGION_REGISTRY_DEFINES_SVH

// invariant, checked every cycle out of reset
`define NRR_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define NRR_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/nrr_pkg.sv
// Named region registry package: request codes, status codes, sequencer states.
// No dependencies.
package nrr_pkg;

  localparam logic FUNC_ATTACH  = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    STAT_ATTACHED = 3'd0,
    STAT_CREATED  = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_RELEASED = 3'd3,
    STAT_NOT_LIVE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } seq_state_t;

endpackage

// File: hw/rtl/nrr_req_if.sv
// Request channel of the named region registry: valid/ready plus request word.
// No dependencies.
interface nrr_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] name_low;
  logic [63:0] name_high;
  logic [6:0]  release_slot;

  modport source(output valid, func, name_low, name_high, release_slot, input ready);
  modport sink(input valid, func, name_low, name_high, release_slot, output ready);
endinterface

// File: hw/rtl/nrr_rsp_if.sv
// Response channel of the named region registry: valid/ready plus result word.
// No dependencies.
interface nrr_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [6:0] slot;
  logic [7:0] ref_count;
  logic [7:0] live_count;

  modport source(output valid, status, slot, ref_count, live_count, input ready);
  modport sink(input valid, status, slot, ref_count, live_count, output ready);
endinterface

// File: hw/rtl/nrr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nrr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/nrr_name_cmp.sv
// Name comparator: equal up to and including the first zero byte.
// No dependencies.
module nrr_name_cmp #(
  parameter int NAME_BYTES = 16
) (
  input  logic [63:0] a_low,
  input  logic [63:0] a_high,
  input  logic [63:0] b_low,
  input  logic [63:0] b_high,
  output logic        equal
);

  logic [127:0] a;
  logic [127:0] b;

  assign a = {a_high, a_low};
  assign b = {b_high, b_low};

  always_comb begin
    logic ok;
    logic zero_seen;
    ok        = 1'b1;
    zero_seen = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (!zero_seen && (a[8*i +: 8] != b[8*i +: 8])) begin
        ok = 1'b0;
      end
      if (a[8*i +: 8] == 8'd0) begin
        zero_seen = 1'b1;
      end
    end
    equal = ok;
  end

endmodule

// File: hw/rtl/named_region_registry.sv
// Named region registry: a table of TABLE_SLOTS named regions with reference counts.
// An attach walks the name store one slot per clock through a single name
// comparator and finishes sooner when a match is found early; an attach to a full
// table and any release skip the walk and go straight to the finish state. Live
// flags sit in flip-flops and are cleared by reset, so no clearing pass is needed.
// One request is in flight at a time; the next request is taken while the previous
// word waits on rsp.
// Depends on nrr_pkg, nrr_req_if, nrr_rsp_if, nrr_ram, nrr_name_cmp and the defines.
`include "named_region_registry_defines.svh"

module named_region_registry
  import nrr_pkg::*;
#(
  parameter int TABLE_SLOTS = 128,
  parameter int NAME_BYTES  = 16
) (
  input  logic       clk,
  input  logic       rst,
  nrr_req_if.sink    req,
  nrr_rsp_if.source  rsp
);

  localparam int IDXW = $clog2(TABLE_SLOTS);
  localparam int CNTW = $clog2(TABLE_SLOTS + 1);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TABLE_SLOTS - 1);

  seq_state_t state, state_next;

  logic [TABLE_SLOTS-1:0] live;
  logic [CNTW-1:0]        total;
  logic [CNTW-1:0]        total_next;

  logic [63:0]     name_low;
  logic [63:0]     name_high;
  logic [IDXW-1:0] scan_idx;
  logic            issue_on;
  logic            cmp_valid;
  logic [IDXW-1:0] cmp_idx;
  logic            free_found;
  logic [IDXW-1:0] free_idx;
  status_t         res_status;
  logic [IDXW-1:0] res_slot;
  logic [7:0]      res_refs;

  logic       out_valid;
  status_t    out_status;
  logic [6:0] out_slot;
  logic [7:0] out_refs;
  logic [7:0] out_live;

  logic            accept;
  logic            out_free;
  logic            commit;
  logic [IDXW-1:0] hidx;
  logic            h_in_range;
  logic            rel_live;
  logic            table_full;
  logic            start_scan;

  logic [63:0]     rd_low;
  logic [63:0]     rd_high;
  logic [7:0]      rd_refs;
  logic            name_eq;
  logic            cmp_live;
  logic            hit;
  logic            cmp_last;
  logic [IDXW-1:0] free_sel;
  logic [7:0]      refs_inc;

  logic            name_we;
  logic            refs_we;

  assign req.ready  = (state == S_IDLE) && !rst;
  assign accept     = req.valid && req.ready;
  assign out_free   = !out_valid || rsp.ready;
  assign commit     = (state == S_FINISH) && out_free;
  assign hidx       = IDXW'(req.release_slot);
  assign h_in_range = {25'd0, req.release_slot} < 32'(TABLE_SLOTS);
  assign rel_live   = h_in_range && live[hidx];
  assign table_full = total >= CNTW'(TABLE_SLOTS);
  assign start_scan = accept && (req.func == FUNC_ATTACH) && !table_full;

  assign cmp_live = live[cmp_idx];
  assign hit      = cmp_valid && cmp_live && name_eq;
  assign cmp_last = cmp_valid && (cmp_idx == LAST_IDX);
  assign free_sel = free_found ? free_idx : cmp_idx;
  assign refs_inc = (rd_refs == 8'hFF) ? 8'hFF : rd_refs + 8'd1;

  nrr_ram #(.WIDTH(64), .DEPTH(TABLE_SLOTS)) u_name_low (
    .clk   (clk),
    .we    (name_we),
    .waddr (res_slot),
    .wdata (name_low),
    .raddr (scan_idx),
    .rdata (rd_low)
  );

  nrr_ram #(.WIDTH(64), .DEPTH(TABLE_SLOTS)) u_name_high (
    .clk   (clk),
    .we    (name_we),
    .waddr (res_slot),
    .wdata (name_high),
    .raddr (scan_idx),
    .rdata (rd_high)
  );

  nrr_ram #(.WIDTH(8), .DEPTH(TABLE_SLOTS)) u_refs (
    .clk   (clk),
    .we    (refs_we),
    .waddr (res_slot),
    .wdata (res_refs),
    .raddr (scan_idx),
    .rdata (rd_refs)
  );

  nrr_name_cmp #(.NAME_BYTES(NAME_BYTES)) u_cmp (
    .a_low  (rd_low),
    .a_high (rd_high),
    .b_low  (name_low),
    .b_high (name_high),
    .equal  (name_eq)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = start_scan ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        if (hit || cmp_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    name_we    = 1'b0;
    refs_we    = 1'b0;
    total_next = total;
    unique case (state) inside
      S_FINISH: begin
        if (commit) begin
          name_we = (res_status == STAT_CREATED);
          refs_we = (res_status == STAT_CREATED) || (res_status == STAT_ATTACHED);
          if (res_status == STAT_CREATED) begin
            total_next = total + CNTW'(1);
          end else if (res_status == STAT_RELEASED) begin
            total_next = total - CNTW'(1);
          end
        end
      end
      S_IDLE, S_SCAN: begin
        name_we = 1'b0;
      end
      default: name_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      live       <= '0;
      total      <= '0;
      out_valid  <= 1'b0;
      issue_on   <= 1'b0;
      cmp_valid  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (commit) begin
        total <= total_next;
        if (res_status == STAT_RELEASED) begin
          live[res_slot] <= 1'b0;
        end else if (res_status == STAT_CREATED) begin
          live[res_slot] <= 1'b1;
        end
      end
      if (start_scan) begin
        issue_on   <= 1'b1;
        cmp_valid  <= 1'b0;
        free_found <= 1'b0;
      end else if (state == S_SCAN) begin
        if (hit || cmp_last) begin
          issue_on  <= 1'b0;
          cmp_valid <= 1'b0;
        end else begin
          cmp_valid <= issue_on;
          if (issue_on && (scan_idx == LAST_IDX)) begin
            issue_on <= 1'b0;
          end
        end
        if (cmp_valid && !cmp_live) begin
          free_found <= 1'b1;
        end
      end else begin
        issue_on  <= 1'b0;
        cmp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      name_low  <= req.name_low;
      name_high <= req.name_high;
      scan_idx  <= '0;
      res_refs  <= 8'd0;
      if (req.func == FUNC_RELEASE) begin
        res_status <= rel_live ? STAT_RELEASED : STAT_NOT_LIVE;
        res_slot   <= rel_live ? hidx : '0;
      end else begin
        res_status <= STAT_FULL;
        res_slot   <= '0;
      end
    end else if (state == S_SCAN) begin
      if (issue_on) begin
        scan_idx <= scan_idx + IDXW'(1);
      end
      cmp_idx <= scan_idx;
      if (cmp_valid && !cmp_live && !free_found) begin
        free_idx <= cmp_idx;
      end
      if (hit) begin
        res_status <= STAT_ATTACHED;
        res_slot   <= cmp_idx;
        res_refs   <= refs_inc;
      end else if (cmp_last) begin
        res_status <= STAT_CREATED;
        res_slot   <= free_sel;
        res_refs   <= 8'd1;
      end
    end
    if (commit) begin
      out_status <= res_status;
      out_slot   <= 7'(res_slot);
      out_refs   <= res_refs;
      out_live   <= 8'(total_next);
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.slot       = out_slot;
  assign rsp.ref_count  = out_refs;
  assign rsp.live_count = out_live;

  `NRR_ASSERT_ALWAYS(a_total_matches_live, $countones(live) == int'(total), "live total out of step with live flags")
  `NRR_ASSERT_IMPLY(a_create_is_free, (state == S_FINISH) && (res_status == STAT_CREATED), !live[res_slot], "claiming a slot that is live")
  `NRR_ASSERT_IMPLY(a_attach_is_live, (state == S_FINISH) && (res_status == STAT_ATTACHED), live[res_slot] && (res_refs != 8'd0), "attach to a slot that is not live")
  `NRR_ASSERT_IMPLY(a_full_only_when_full, (state == S_FINISH) && (res_status == STAT_FULL), total == CNTW'(TABLE_SLOTS), "table full reported with free slots")
  `NRR_ASSERT_NEXT(a_commit_shows_word, commit, out_valid && (state == S_IDLE), "finished request left no response word")

endmodule
